>>> src/bilinear_zoom_2x_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 2x bilinear zoom core.
// Both macros sample on clk and are disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_ZOOM_2X_CORE_ASSERT_SVH
`define BILINEAR_ZOOM_2X_CORE_ASSERT_SVH

// Same-cycle implication.
`define BZ2_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BZ2_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/bz2_pkg.sv
// ----------------------------------------------------------------------------
// bz2_pkg
// Types and constants shared by the 2x bilinear zoom modules.
// ----------------------------------------------------------------------------
package bz2_pkg;

    localparam int PIX_W    = 8;
    localparam int COORD_W  = 11;
    localparam int CFG_W    = 11;
    localparam int PDATA_W  = 32;
    localparam int PADDR_W  = 3;
    localparam int TDATA_W  = 32;
    localparam int SIZE_RST = 1024;

    // Register index taken from paddr[2].
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    // Which of the up to four output pixels is being produced.
    typedef enum logic [3:0] {
        KIND_SELF   = 4'b0001,
        KIND_LEFT   = 4'b0010,
        KIND_UP     = 4'b0100,
        KIND_CORNER = 4'b1000
    } kind_t;

    // One input pixel with its neighbors, ready for the result sequencer.
    typedef struct packed {
        logic [PIX_W-1:0]   pix;
        logic [PIX_W-1:0]   left;
        logic [PIX_W-1:0]   above;
        logic [PIX_W-1:0]   upleft;
        logic [COORD_W-1:0] orow;
        logic [COORD_W-1:0] ocol;
        logic               has_left;
        logic               has_up;
        logic               frame_last;
    } job_t;

endpackage

>>> src/bz2_linebuf.sv
// ----------------------------------------------------------------------------
// bz2_linebuf
// Single-port previous-row memory with read-before-write and registered read.
// ----------------------------------------------------------------------------
module bz2_linebuf #(
    parameter int DEPTH = 1024
) (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic                                 we,
    input  logic [$clog2(DEPTH)-1:0]             addr,
    input  logic [bz2_pkg::PIX_W-1:0]            wdata,
    output logic [bz2_pkg::PIX_W-1:0]            rdata
);
    import bz2_pkg::*;

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] rdata_reg;

    // The read returns the old entry; the data holds until the next access.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata_reg <= mem[addr];
            if (we)
            begin
                mem[addr] <= wdata;
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/bz2_emit.sv
// ----------------------------------------------------------------------------
// bz2_emit
// Holds one pixel job and sends its one to four results through an
// output register, one word per cycle while m_tready is high.
// ----------------------------------------------------------------------------
module bz2_emit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          job_valid,
    input  bz2_pkg::job_t                 job,
    output logic                          job_take,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bz2_pkg::TDATA_W-1:0]   m_tdata,   // out_row, out_col, out_value, zero pad
    output logic                          m_tlast,   // run_last
    output logic                          m_tuser    // frame_done
);
    import bz2_pkg::*;

    job_t                job_reg;
    logic                busy_reg, busy_next;
    kind_t               kind_reg, kind_next;
    logic                mvalid_reg;
    logic [COORD_W-1:0]  row_reg;
    logic [COORD_W-1:0]  col_reg;
    logic [PIX_W-1:0]    val_reg;
    logic                last_reg;
    logic                done_reg;

    logic                out_load;
    logic                emit;
    logic                last;
    kind_t               kind_after;
    logic [PIX_W:0]      sum_left;
    logic [PIX_W:0]      sum_up;
    logic [PIX_W+1:0]    sum_all;
    logic [PIX_W-1:0]    val;
    logic [COORD_W-1:0]  row;
    logic [COORD_W-1:0]  col;

    assign out_load = !mvalid_reg || m_tready;
    assign emit     = busy_reg && out_load;

    always_comb
    begin
        kind_after = KIND_SELF;
        last       = 1'b1;
        case (kind_reg)
            KIND_SELF:
            begin
                if (job_reg.has_left)
                begin
                    kind_after = KIND_LEFT;
                    last       = 1'b0;
                end
                else if (job_reg.has_up)
                begin
                    kind_after = KIND_UP;
                    last       = 1'b0;
                end
            end
            KIND_LEFT:
            begin
                if (job_reg.has_up)
                begin
                    kind_after = KIND_UP;
                    last       = 1'b0;
                end
            end
            KIND_UP:
            begin
                if (job_reg.has_left)
                begin
                    kind_after = KIND_CORNER;
                    last       = 1'b0;
                end
            end
            KIND_CORNER:
            begin
                last = 1'b1;
            end
            default:
            begin
                last = 1'b1;
            end
        endcase
    end

    assign sum_left = {1'b0, job_reg.left} + {1'b0, job_reg.pix};
    assign sum_up   = {1'b0, job_reg.above} + {1'b0, job_reg.pix};
    assign sum_all  = {1'b0, sum_left} + {2'b00, job_reg.above} + {2'b00, job_reg.upleft};

    always_comb
    begin
        val = job_reg.pix;
        row = job_reg.orow;
        col = job_reg.ocol;
        case (kind_reg)
            KIND_SELF:
            begin
                val = job_reg.pix;
            end
            KIND_LEFT:
            begin
                val = sum_left[PIX_W:1];
                col = job_reg.ocol - COORD_W'(1);
            end
            KIND_UP:
            begin
                val = sum_up[PIX_W:1];
                row = job_reg.orow - COORD_W'(1);
            end
            KIND_CORNER:
            begin
                val = sum_all[PIX_W+1:2];
                row = job_reg.orow - COORD_W'(1);
                col = job_reg.ocol - COORD_W'(1);
            end
            default:
            begin
                val = job_reg.pix;
            end
        endcase
    end

    // A new job enters when the slot is empty or its last word leaves now.
    assign job_take = job_valid && (!busy_reg || (emit && last));

    always_comb
    begin
        busy_next = busy_reg;
        kind_next = kind_reg;
        if (job_take)
        begin
            busy_next = 1'b1;
            kind_next = KIND_SELF;
        end
        else if (emit)
        begin
            busy_next = !last;
            kind_next = last ? KIND_SELF : kind_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            kind_reg   <= KIND_SELF;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            kind_reg <= kind_next;
            if (out_load)
            begin
                mvalid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_take)
        begin
            job_reg <= job;
        end
        if (emit)
        begin
            row_reg  <= row;
            col_reg  <= col;
            val_reg  <= val;
            last_reg <= last;
            done_reg <= last && job_reg.frame_last;
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = TDATA_W'({val_reg, col_reg, row_reg});
    assign m_tlast  = last_reg;
    assign m_tuser  = done_reg;

endmodule

>>> src/bilinear_zoom_2x_core.sv
// ----------------------------------------------------------------------------
// bilinear_zoom_2x_core
// 2x bilinear enlargement of an 8-bit grey image streamed in raster order.
// ----------------------------------------------------------------------------
// Pixels enter on the s_ channel, one per word, in raster order of an
// image_rows by image_cols image. Each pixel produces one to four words on
// the m_ channel: the pixel itself at (2r,2c), then the left mean at
// (2r,2c-1) when c>0, the upper mean at (2r-1,2c) when r>0, and the
// four-corner mean at (2r-1,2c-1) when both hold. tlast marks the final
// word of a pixel and tuser the final word of the frame.
// On its way to the output a pixel passes the s1 registers, the job
// register of the sequencer and the output register. The output carries
// one word per cycle while m_tready is high; the next pixel is fetched
// from the row memory while the current one is still emitting.
// The previous row sits in a single-port memory of MAX_COLS entries that is
// read and written at the same address on acceptance.
// Reset clears the position to (0,0) and sets both sizes to 1024; writing
// either size register over APB also restarts the frame. When m_tready is
// low the output word holds and s_tready drops once the two internal
// stages are full.
// ----------------------------------------------------------------------------
module bilinear_zoom_2x_core #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // pixel_in
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bz2_pkg::TDATA_W-1:0]   m_tdata,   // out_row, out_col, out_value, zero pad
    output logic                          m_tlast,   // run_last
    output logic                          m_tuser,   // frame_done
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bz2_pkg::PADDR_W-1:0]   paddr,
    input  logic [bz2_pkg::PDATA_W-1:0]   pwdata,
    output logic [bz2_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import bz2_pkg::*;

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int CCW   = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
    localparam int CRW   = (ROW_W + 1 > CFG_W) ? ROW_W + 1 : CFG_W;

    logic [CFG_W-1:0]    rows_reg;
    logic [CFG_W-1:0]    cols_reg;
    logic [ROW_W-1:0]    row_cnt_reg, row_cnt_next;
    logic [COL_W-1:0]    col_cnt_reg, col_cnt_next;

    logic                s1_valid_reg;
    logic [PIX_W-1:0]    s1_pix_reg;
    logic [COORD_W-1:0]  s1_orow_reg;
    logic [COORD_W-1:0]  s1_ocol_reg;
    logic                s1_has_left_reg;
    logic                s1_has_up_reg;
    logic                s1_last_reg;
    logic [PIX_W-1:0]    left_reg;
    logic [PIX_W-1:0]    upleft_reg;

    logic                cfg_wr;
    logic                accept;
    logic                job_take;
    logic                last_col;
    logic                last_row;
    logic [PIX_W-1:0]    above;
    job_t                job;

    // ---------------- configuration ----------------
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_COLS) ? PDATA_W'(cols_reg) : PDATA_W'(rows_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= CFG_W'(SIZE_RST);
            cols_reg <= CFG_W'(SIZE_RST);
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_ROWS)
            begin
                rows_reg <= pwdata[CFG_W-1:0];
            end
            else
            begin
                cols_reg <= pwdata[CFG_W-1:0];
            end
        end
    end

    // ---------------- position ----------------
    // A size of zero acts as one and a size above the maximum as the maximum.
    assign last_col = (cols_reg == '0)
                   || (CCW'(col_cnt_reg) + CCW'(1) >= CCW'(cols_reg))
                   || (CCW'(col_cnt_reg) + CCW'(1) >= CCW'(MAX_COLS));
    assign last_row = (rows_reg == '0)
                   || (CRW'(row_cnt_reg) + CRW'(1) >= CRW'(rows_reg))
                   || (CRW'(row_cnt_reg) + CRW'(1) >= CRW'(MAX_ROWS));

    assign s_tready = !s1_valid_reg || job_take;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        row_cnt_next = row_cnt_reg;
        col_cnt_next = col_cnt_reg;
        if (cfg_wr)
        begin
            row_cnt_next = '0;
            col_cnt_next = '0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_cnt_next = '0;
                row_cnt_next = last_row ? '0 : row_cnt_reg + ROW_W'(1);
            end
            else
            begin
                col_cnt_next = col_cnt_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg  <= '0;
            col_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
            left_reg     <= '0;
            upleft_reg   <= '0;
        end
        else
        begin
            row_cnt_reg <= row_cnt_next;
            col_cnt_reg <= col_cnt_next;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (job_take)
            begin
                s1_valid_reg <= 1'b0;
            end
            // The neighbors follow pixels in the order they enter the sequencer.
            if (job_take)
            begin
                left_reg   <= s1_pix_reg;
                upleft_reg <= above;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg      <= s_tdata;
            s1_orow_reg     <= COORD_W'({row_cnt_reg, 1'b0});
            s1_ocol_reg     <= COORD_W'({col_cnt_reg, 1'b0});
            s1_has_left_reg <= (col_cnt_reg != '0);
            s1_has_up_reg   <= (row_cnt_reg != '0);
            s1_last_reg     <= last_col && last_row;
        end
    end

    // ---------------- row memory ----------------
    // Read of the old entry and write of the new pixel share the accept cycle.
    bz2_linebuf #(
        .DEPTH (MAX_COLS)
    ) u_linebuf (
        .clk   (clk),
        .en    (accept),
        .we    (accept),
        .addr  (col_cnt_reg),
        .wdata (s_tdata),
        .rdata (above)
    );

    // ---------------- result sequencer ----------------
    always_comb
    begin
        job.pix        = s1_pix_reg;
        job.left       = left_reg;
        job.above      = above;
        job.upleft     = upleft_reg;
        job.orow       = s1_orow_reg;
        job.ocol       = s1_ocol_reg;
        job.has_left   = s1_has_left_reg;
        job.has_up     = s1_has_up_reg;
        job.frame_last = s1_last_reg;
    end

    bz2_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (s1_valid_reg),
        .job       (job),
        .job_take  (job_take),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

>>> src/bz2_checker.sv
// ----------------------------------------------------------------------------
// bz2_checker
// Port-level checks on the result stream of the 2x bilinear zoom core.
// ----------------------------------------------------------------------------
`include "bilinear_zoom_2x_core_assert.svh"

module bz2_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [bz2_pkg::TDATA_W-1:0]   m_tdata,
    input  logic                          m_tlast,
    input  logic                          m_tuser
);
    import bz2_pkg::*;

    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;

    assign row = m_tdata[COORD_W-1:0];
    assign col = m_tdata[2*COORD_W-1:COORD_W];

    `BZ2_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "result word changed while stalled")
    `BZ2_ASSERT_NOW(a_done_last, m_tvalid && m_tuser, m_tlast, "frame end not on the last word of a pixel")
    `BZ2_ASSERT_NOW(a_corner_last, m_tvalid && row[0] && col[0], m_tlast, "corner mean is not the last word of its pixel")
    `BZ2_ASSERT_NOW(a_self_more, m_tvalid && !row[0] && !col[0] && (col != '0), !m_tlast, "pixel with a left neighbor ended after one word")

endmodule

bind bilinear_zoom_2x_core bz2_checker u_bz2_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
